[rtl/usb_control_transfer_stage_fsm_defines.svh]
// Assertion helpers for the RTL file that checks its own logic.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef USB_CONTROL_TRANSFER_STAGE_FSM_DEFINES_SVH
`define USB_CONTROL_TRANSFER_STAGE_FSM_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define UCTS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define UCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ucts_pkg.sv]
package ucts_pkg;

    // Packet type and stage codes as seen on the ports
    localparam logic [2:0] PT_SETUP = 3'd0;
    localparam logic [2:0] PT_DOUT  = 3'd1;
    localparam logic [2:0] PT_SIN   = 3'd2;
    localparam logic [2:0] PT_DIN   = 3'd3;
    localparam logic [2:0] PT_SOUT  = 3'd4;

    // Function codes
    localparam logic [2:0] FN_PKT    = 3'd0;
    localparam logic [2:0] FN_READ   = 3'd1;
    localparam logic [2:0] FN_WRITE  = 3'd2;
    localparam logic [2:0] FN_STATUS = 3'd3;
    localparam logic [2:0] FN_STALL  = 3'd4;

    // Callback codes
    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_SETUP  = 4'd1;
    localparam logic [3:0] ACT_DIN    = 4'd2;
    localparam logic [3:0] ACT_DOUT   = 4'd3;
    localparam logic [3:0] ACT_SIN    = 4'd4;
    localparam logic [3:0] ACT_SOUT   = 4'd5;
    localparam logic [3:0] ACT_READ   = 4'd6;
    localparam logic [3:0] ACT_WRITE  = 4'd7;
    localparam logic [3:0] ACT_STATUS = 4'd8;
    localparam logic [3:0] ACT_STALL  = 4'd9;

    // Callback status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_GEN  = 2'd1;
    localparam logic [1:0] STS_NRDY = 2'd2;
    localparam logic [1:0] STS_PASS = 2'd3;

    typedef enum logic [4:0] {
        STG_SETUP = 5'b00001,
        STG_DOUT  = 5'b00010,
        STG_SIN   = 5'b00100,
        STG_DIN   = 5'b01000,
        STG_SOUT  = 5'b10000
    } stage_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [2:0]        pkt_type;
        logic [6:0]        pkt_size;
        logic signed [7:0] error_in;
        logic [7:0]        request_type;
        logic [15:0]       setup_length;
        logic [4:0]        endpoint;
    } item_t;

    typedef struct packed {
        logic [3:0]        action;
        logic [1:0]        status;
        logic signed [7:0] error_value;
        logic [6:0]        size_out;
        logic [4:0]        endpoint_out;
        logic [2:0]        stage_out;
        logic              last;
    } result_t;

    typedef struct packed {
        stage_t      stage;
        logic        read_pending;
        logic [15:0] bytes_received;
        logic [15:0] expected_length;
    } ctx_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
        ctx_t       ctx;
    } step_t;

    function automatic logic [2:0] stage_code(input stage_t stg);
        logic [2:0] code;
        unique case (stg)
            STG_SETUP: code = PT_SETUP;
            STG_DOUT:  code = PT_DOUT;
            STG_SIN:   code = PT_SIN;
            STG_DIN:   code = PT_DIN;
            STG_SOUT:  code = PT_SOUT;
            default:   code = PT_SETUP;
        endcase
        return code;
    endfunction

    function automatic result_t mk_result(
        input logic [3:0]        act,
        input logic [1:0]        sts,
        input logic signed [7:0] err,
        input logic [6:0]        size,
        input logic [4:0]        ep,
        input stage_t            stg
    );
        result_t r;
        r.action       = act;
        r.status       = sts;
        r.error_value  = (sts == STS_PASS) ? err : 8'sd0;
        r.size_out     = size;
        r.endpoint_out = ep;
        r.stage_out    = stage_code(stg);
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

[rtl/ucts_cmd_if.sv]
interface ucts_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [2:0]        pkt_type;
    logic [6:0]        pkt_size;
    logic signed [7:0] error_in;
    logic [7:0]        request_type;
    logic [15:0]       setup_length;
    logic [4:0]        endpoint;

    modport source (
        output valid, func, pkt_type, pkt_size, error_in, request_type,
               setup_length, endpoint,
        input  ready
    );

    modport sink (
        input  valid, func, pkt_type, pkt_size, error_in, request_type,
               setup_length, endpoint,
        output ready
    );
endinterface

[rtl/ucts_rsp_if.sv]
interface ucts_rsp_if;
    logic              valid;
    logic              ready;
    logic [3:0]        action;
    logic [1:0]        status;
    logic signed [7:0] error_value;
    logic [6:0]        size_out;
    logic [4:0]        endpoint_out;
    logic [2:0]        stage_out;
    logic              last;

    modport source (
        output valid, action, status, error_value, size_out, endpoint_out,
               stage_out, last,
        input  ready
    );

    modport sink (
        input  valid, action, status, error_value, size_out, endpoint_out,
               stage_out, last,
        output ready
    );
endinterface

[rtl/usb_control_transfer_stage_fsm.sv]
// Endpoint-0 control transfer stage tracker.
// cmd carries one event per beat: a packet completion, a client read, write
// or send-status request, or a stall. rsp carries the callback results that
// the event causes, in order; last marks the final result of each event.
// An event is held in an input register, decoded in one pass, and its
// results are loaded into an output register.
// Most events give one result, and one event is taken per cycle while rsp is not stalled. A setup
// packet that arrives mid-transfer gives two results (abandoned stage, then
// setup), loaded into the output register one after the other. Function codes
// with no meaning give no result and retire without using the output register.
// Stage state is committed when the event's last result is loaded.
// While rsp is stalled the output register holds its result, the input
// register keeps one more event, and cmd ready drops once both are full.
// Reset returns the stage to setup with no read pending and empty counts;
// both registers come up empty.
`include "usb_control_transfer_stage_fsm_defines.svh"

module usb_control_transfer_stage_fsm (
    input  logic       clk,
    input  logic       rst_n,
    ucts_cmd_if.sink   cmd,
    ucts_rsp_if.source rsp
);
    import ucts_pkg::*;

    logic    ir_valid_reg;
    logic    ir_valid_next;
    item_t   ir_reg;
    item_t   ir_next;
    ctx_t    ctx_reg;
    ctx_t    ctx_next;
    logic    phase_reg;
    logic    phase_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    step_t   step;
    logic    out_free;
    logic    emit;
    logic    consume;
    logic    cmd_take;

    ucts_step u_step (
        .item (ir_reg),
        .cur  (ctx_reg),
        .step (step)
    );

    // Handshake control
    always_comb
    begin
        out_free = !out_valid_reg || rsp.ready;
        emit     = ir_valid_reg && (step.count != 2'd0) && out_free;
        consume  = ir_valid_reg && ((step.count == 2'd0) ||
                   (out_free && ((step.count == 2'd1) || phase_reg)));
        cmd_take = cmd.valid && cmd.ready;
    end

    assign cmd.ready = !ir_valid_reg || consume;

    // Next values: input register, context, phase and output register
    always_comb
    begin
        ir_valid_next = ir_valid_reg;
        ir_next       = ir_reg;
        if (consume)
        begin
            ir_valid_next = 1'b0;
        end
        if (cmd_take)
        begin
            ir_valid_next         = 1'b1;
            ir_next.func          = cmd.func;
            ir_next.pkt_type      = cmd.pkt_type;
            ir_next.pkt_size      = cmd.pkt_size;
            ir_next.error_in      = cmd.error_in;
            ir_next.request_type  = cmd.request_type;
            ir_next.setup_length  = cmd.setup_length;
            ir_next.endpoint      = cmd.endpoint;
        end

        ctx_next = consume ? step.ctx : ctx_reg;

        // Advance to the second result of a two-result beat
        phase_next = phase_reg;
        if (emit && (step.count == 2'd2))
        begin
            phase_next = !phase_reg;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next = (step.count == 2'd2 && phase_reg) ? step.second : step.first;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg          <= 1'b0;
            phase_reg             <= 1'b0;
            out_valid_reg         <= 1'b0;
            ctx_reg.stage           <= STG_SETUP;
            ctx_reg.read_pending    <= 1'b0;
            ctx_reg.bytes_received  <= 16'd0;
            ctx_reg.expected_length <= 16'd0;
        end
        else
        begin
            ir_valid_reg  <= ir_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            ctx_reg       <= ctx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ir_reg  <= ir_next;
        out_reg <= out_next;
    end

    // Drive the result channel
    assign rsp.valid        = out_valid_reg;
    assign rsp.action       = out_reg.action;
    assign rsp.status       = out_reg.status;
    assign rsp.error_value  = out_reg.error_value;
    assign rsp.size_out     = out_reg.size_out;
    assign rsp.endpoint_out = out_reg.endpoint_out;
    assign rsp.stage_out    = out_reg.stage_out;
    assign rsp.last         = out_reg.last;

    `UCTS_ASSERT_IMPLY(a_phase_owner, phase_reg,
        ir_valid_reg && (step.count == 2'd2), "second-result phase without a two-result beat")
    `UCTS_ASSERT_NEXT(a_first_holds, emit && !phase_reg && (step.count == 2'd2),
        phase_reg && ir_valid_reg, "two-result beat retired after its first result")
    `UCTS_ASSERT_IMPLY(a_non_last, out_valid_reg && !out_reg.last,
        phase_reg, "non-final result waiting with no second result due")
    `UCTS_ASSERT_NEXT(a_stall_clears, consume && (ir_reg.func == FN_STALL),
        !ctx_reg.read_pending && (ctx_reg.stage == STG_SETUP), "stall left state behind")

endmodule

[rtl/ucts_step.sv]
module ucts_step (
    input  ucts_pkg::item_t item,
    input  ucts_pkg::ctx_t  cur,
    output ucts_pkg::step_t step
);
    import ucts_pkg::*;

    logic        setup_pkt;
    logic [1:0]  ps;
    stage_t      setup_stg;
    logic [16:0] sum;
    logic [15:0] bytes_sat;

    // Stage that a fresh setup packet selects
    always_comb
    begin
        setup_pkt = (item.pkt_type == PT_SETUP);
        ps        = (item.error_in != 8'sd0) ? STS_PASS : STS_OK;
        if (item.setup_length == 16'd0)
        begin
            setup_stg = STG_SIN;
        end
        else if (item.request_type[7])
        begin
            setup_stg = STG_DIN;
        end
        else
        begin
            setup_stg = STG_DOUT;
        end
        // Saturating data-out byte count
        sum       = {1'b0, cur.bytes_received} + {10'd0, item.pkt_size};
        bytes_sat = sum[16] ? 16'hFFFF : sum[15:0];
    end

    // Decode one beat into its results and the following context
    always_comb
    begin
        step.count  = 2'd0;
        step.first  = '0;
        step.second = '0;
        step.ctx    = cur;

        unique case (item.func)
            FN_PKT:
            begin
                if (setup_pkt)
                begin
                    step.ctx.expected_length = item.setup_length;
                    step.ctx.bytes_received  = 16'd0;
                end
                unique case (cur.stage)
                    STG_SETUP:
                    begin
                        if (setup_pkt)
                        begin
                            step.count = 2'd1;
                            step.ctx.stage = setup_stg;
                            step.ctx.read_pending = 1'b0;
                            step.first = mk_result(ACT_SETUP, ps, item.error_in,
                                                   item.pkt_size, 5'd0, setup_stg);
                        end
                    end
                    STG_DIN:
                    begin
                        step.count = 2'd1;
                        if (setup_pkt)
                        begin
                            step.first = mk_result(ACT_DIN, STS_GEN, item.error_in,
                                                   item.pkt_size, 5'd0, STG_SETUP);
                        end
                        else if (item.pkt_type == PT_DIN)
                        begin
                            step.ctx.stage = STG_SOUT;
                            step.first = mk_result(ACT_DIN, ps, item.error_in,
                                                   item.pkt_size, 5'd0, STG_SOUT);
                        end
                        else
                        begin
                            step.ctx.stage = STG_SETUP;
                            step.first = mk_result(ACT_DIN, STS_GEN, item.error_in,
                                                   item.pkt_size, 5'd0, STG_SETUP);
                        end
                    end
                    STG_SOUT:
                    begin
                        step.count = 2'd1;
                        step.ctx.stage = STG_SETUP;
                        if (setup_pkt || item.pkt_type == PT_SOUT)
                        begin
                            step.first = mk_result(ACT_SOUT, ps, item.error_in,
                                                   7'd0, 5'd0, STG_SETUP);
                        end
                        else
                        begin
                            step.first = mk_result(ACT_SOUT, STS_GEN, item.error_in,
                                                   7'd0, 5'd0, STG_SETUP);
                        end
                    end
                    STG_DOUT:
                    begin
                        step.count = 2'd1;
                        step.ctx.read_pending = 1'b0;
                        if (setup_pkt)
                        begin
                            step.first = mk_result(ACT_DOUT, STS_GEN, item.error_in,
                                                   item.pkt_size, 5'd0, STG_SETUP);
                        end
                        else if (item.pkt_type == PT_DOUT)
                        begin
                            step.ctx.bytes_received = bytes_sat;
                            if (bytes_sat >= cur.expected_length)
                            begin
                                step.ctx.stage = STG_SIN;
                            end
                            step.first = mk_result(ACT_DOUT, ps, item.error_in,
                                                   item.pkt_size, 5'd0, step.ctx.stage);
                        end
                        else if (item.pkt_type == PT_SIN)
                        begin
                            step.ctx.stage = STG_SETUP;
                            step.first = mk_result(ACT_DOUT, ps, item.error_in,
                                                   item.pkt_size, 5'd0, STG_SETUP);
                        end
                        else
                        begin
                            step.ctx.stage = STG_SETUP;
                            step.first = mk_result(ACT_DOUT, STS_GEN, item.error_in,
                                                   item.pkt_size, 5'd0, STG_SETUP);
                        end
                    end
                    STG_SIN:
                    begin
                        step.count = 2'd1;
                        step.ctx.stage = STG_SETUP;
                        if (setup_pkt || item.pkt_type == PT_SIN)
                        begin
                            step.first = mk_result(ACT_SIN, STS_OK, item.error_in,
                                                   7'd0, 5'd0, STG_SETUP);
                        end
                        else
                        begin
                            step.first = mk_result(ACT_SIN, STS_GEN, item.error_in,
                                                   7'd0, 5'd0, STG_SETUP);
                        end
                    end
                    default:
                    begin
                        step.ctx.stage = STG_SETUP;
                    end
                endcase

                // Setup in mid-transfer: close the old stage, then start anew
                if (setup_pkt && cur.stage != STG_SETUP)
                begin
                    step.count = 2'd2;
                    step.ctx.stage = setup_stg;
                    step.ctx.read_pending = 1'b0;
                    step.second = mk_result(ACT_SETUP, ps, item.error_in,
                                            item.pkt_size, 5'd0, setup_stg);
                end
            end
            FN_READ:
            begin
                step.count = 2'd1;
                if (cur.stage == STG_DIN)
                begin
                    step.first = mk_result(ACT_NONE, STS_NRDY, 8'sd0, 7'd0, 5'd0,
                                           cur.stage);
                end
                else if (cur.read_pending)
                begin
                    step.first = mk_result(ACT_NONE, STS_OK, 8'sd0, 7'd0, 5'd0,
                                           cur.stage);
                end
                else
                begin
                    step.ctx.read_pending = 1'b1;
                    step.first = mk_result(ACT_READ, STS_OK, 8'sd0, 7'd0, 5'd0,
                                           cur.stage);
                end
            end
            FN_WRITE:
            begin
                step.count = 2'd1;
                if (cur.stage == STG_DIN)
                begin
                    step.first = mk_result(ACT_WRITE, STS_OK, 8'sd0, 7'd0, 5'd0,
                                           cur.stage);
                end
                else
                begin
                    step.first = mk_result(ACT_NONE, STS_NRDY, 8'sd0, 7'd0, 5'd0,
                                           cur.stage);
                end
            end
            FN_STATUS:
            begin
                step.count = 2'd1;
                if (cur.stage == STG_SIN)
                begin
                    step.ctx.stage = STG_SETUP;
                    step.first = mk_result(ACT_STATUS, STS_OK, 8'sd0, 7'd0, 5'd0,
                                           STG_SETUP);
                end
                else
                begin
                    step.first = mk_result(ACT_NONE, STS_NRDY, 8'sd0, 7'd0, 5'd0,
                                           cur.stage);
                end
            end
            FN_STALL:
            begin
                step.count = 2'd1;
                step.ctx.stage = STG_SETUP;
                step.ctx.read_pending = 1'b0;
                step.first = mk_result(ACT_STALL, STS_OK, 8'sd0, 7'd0, item.endpoint,
                                       STG_SETUP);
            end
            default:
            begin
                step.count = 2'd0;
            end
        endcase

        // Mark the final result of the beat
        if (step.count == 2'd1)
        begin
            step.first.last = 1'b1;
        end
        if (step.count == 2'd2)
        begin
            step.second.last = 1'b1;
        end
    end

endmodule

[sim/usb_ctrl_stage_checker.sv]
module usb_ctrl_stage_checker (
    input  logic        clk,
    input  logic        rst_n,
    ucts_cmd_if         cmd,
    ucts_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ucts_pkg::*;

    // Shadow copy of the control transfer state
    logic [2:0]  stage_q   = PT_SETUP;
    logic        read_busy = 1'b0;
    logic [15:0] rx_bytes  = '0;
    logic [15:0] wlength   = '0;

    result_t     callbacks_due[$];
    int unsigned mismatches = 0;

    // Build one callback beat tagged with the stage that follows it
    function automatic result_t callback(
        input logic [3:0]        act,
        input logic [1:0]        sts,
        input logic signed [7:0] err,
        input logic [6:0]        size,
        input logic [4:0]        ep
    );
        result_t r;
        r.action       = act;
        r.status       = sts;
        r.error_value  = (sts == STS_PASS) ? err : 8'sd0;
        r.size_out     = size;
        r.endpoint_out = ep;
        r.stage_out    = stage_q;
        r.last         = 1'b0;
        return r;
    endfunction

    // Advance the shadow state by one accepted event and queue its callbacks
    task automatic track_event();
        item_t       it;
        result_t     beat [2];
        int          n;
        logic [1:0]  pass_sts;
        logic [1:0]  sts;
        logic        again;
        int unsigned sum;
        it.func         = cmd.func;
        it.pkt_type     = cmd.pkt_type;
        it.pkt_size     = cmd.pkt_size;
        it.error_in     = cmd.error_in;
        it.request_type = cmd.request_type;
        it.setup_length = cmd.setup_length;
        it.endpoint     = cmd.endpoint;
        n        = 0;
        pass_sts = (it.error_in != 8'sd0) ? STS_PASS : STS_OK;
        case (it.func)
            FN_PKT:
            begin
                // a setup packet reloads the data stage length up front
                if (it.pkt_type == PT_SETUP)
                begin
                    wlength  = it.setup_length;
                    rx_bytes = '0;
                end
                again = 1'b1;
                while (again && n < 2)
                begin
                    again = 1'b0;
                    sts   = pass_sts;
                    case (stage_q)
                        PT_SETUP:
                        begin
                            // drop anything but a setup packet here
                            if (it.pkt_type == PT_SETUP)
                            begin
                                if (wlength == 16'd0)
                                    stage_q = PT_SIN;
                                else if (it.request_type[7])
                                    stage_q = PT_DIN;
                                else
                                    stage_q = PT_DOUT;
                                read_busy = 1'b0;
                                beat[n] = callback(ACT_SETUP, pass_sts, it.error_in,
                                                   it.pkt_size, '0);
                                n++;
                            end
                        end
                        PT_DIN:
                        begin
                            if (it.pkt_type == PT_SETUP)
                            begin
                                sts     = STS_GEN;
                                stage_q = PT_SETUP;
                                again   = 1'b1;
                            end
                            else if (it.pkt_type == PT_DIN)
                                stage_q = PT_SOUT;
                            else
                            begin
                                sts     = STS_GEN;
                                stage_q = PT_SETUP;
                            end
                            beat[n] = callback(ACT_DIN, sts, it.error_in, it.pkt_size, '0);
                            n++;
                        end
                        PT_SOUT:
                        begin
                            if (it.pkt_type == PT_SETUP)
                            begin
                                stage_q = PT_SETUP;
                                again   = 1'b1;
                            end
                            else if (it.pkt_type == PT_SOUT)
                                stage_q = PT_SETUP;
                            else
                            begin
                                sts     = STS_GEN;
                                stage_q = PT_SETUP;
                            end
                            beat[n] = callback(ACT_SOUT, sts, it.error_in, '0, '0);
                            n++;
                        end
                        PT_DOUT:
                        begin
                            if (it.pkt_type == PT_SETUP)
                            begin
                                sts     = STS_GEN;
                                stage_q = PT_SETUP;
                                again   = 1'b1;
                            end
                            else if (it.pkt_type == PT_DOUT)
                            begin
                                // count bytes, saturating at the 16-bit ceiling
                                sum = rx_bytes + it.pkt_size;
                                if (sum > 32'hFFFF)
                                    sum = 32'hFFFF;
                                rx_bytes = 16'(sum);
                                if (rx_bytes >= wlength)
                                    stage_q = PT_SIN;
                            end
                            else if (it.pkt_type == PT_SIN)
                                stage_q = PT_SETUP;
                            else
                            begin
                                sts     = STS_GEN;
                                stage_q = PT_SETUP;
                            end
                            read_busy = 1'b0;
                            beat[n] = callback(ACT_DOUT, sts, it.error_in, it.pkt_size, '0);
                            n++;
                        end
                        default:
                        begin
                            // status in never passes the lower-layer error on
                            sts = STS_OK;
                            if (it.pkt_type == PT_SETUP)
                            begin
                                stage_q = PT_SETUP;
                                again   = 1'b1;
                            end
                            else if (it.pkt_type == PT_SIN)
                                stage_q = PT_SETUP;
                            else
                            begin
                                sts     = STS_GEN;
                                stage_q = PT_SETUP;
                            end
                            beat[n] = callback(ACT_SIN, sts, it.error_in, '0, '0);
                            n++;
                        end
                    endcase
                end
            end
            FN_READ:
            begin
                if (stage_q == PT_DIN)
                    beat[n] = callback(ACT_NONE, STS_NRDY, '0, '0, '0);
                else if (read_busy)
                    beat[n] = callback(ACT_NONE, STS_OK, '0, '0, '0);
                else
                begin
                    read_busy = 1'b1;
                    beat[n] = callback(ACT_READ, STS_OK, '0, '0, '0);
                end
                n++;
            end
            FN_WRITE:
            begin
                if (stage_q == PT_DIN)
                    beat[n] = callback(ACT_WRITE, STS_OK, '0, '0, '0);
                else
                    beat[n] = callback(ACT_NONE, STS_NRDY, '0, '0, '0);
                n++;
            end
            FN_STATUS:
            begin
                if (stage_q == PT_SIN)
                begin
                    stage_q = PT_SETUP;
                    beat[n] = callback(ACT_STATUS, STS_OK, '0, '0, '0);
                end
                else
                    beat[n] = callback(ACT_NONE, STS_NRDY, '0, '0, '0);
                n++;
            end
            FN_STALL:
            begin
                stage_q   = PT_SETUP;
                read_busy = 1'b0;
                beat[n]   = callback(ACT_STALL, STS_OK, '0, '0, it.endpoint);
                n++;
            end
            default:
            begin
                // unknown function codes retire silently
            end
        endcase
        if (n > 0)
            beat[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            callbacks_due.push_back(beat[i]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] callback mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Compare one result beat with the oldest queued callback
    task automatic check_beat();
        result_t want;
        if (callbacks_due.size() == 0)
            report_mismatch($sformatf("beat with nothing queued, action %0d", rsp.action));
        else
        begin
            want = callbacks_due.pop_front();
            check_field("action", rsp.action, want.action);
            check_field("status", rsp.status, want.status);
            check_field("error_value", rsp.error_value, want.error_value);
            check_field("size_out", rsp.size_out, want.size_out);
            check_field("endpoint_out", rsp.endpoint_out, want.endpoint_out);
            check_field("stage_out", rsp.stage_out, want.stage_out);
            check_field("last", rsp.last, want.last);
        end
    endtask

    // Watch both channels: check results first, then queue new predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_q   = PT_SETUP;
            read_busy = 1'b0;
            rx_bytes  = '0;
            wlength   = '0;
            callbacks_due.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_beat();
            if (cmd.valid && cmd.ready)
                track_event();
        end
        fail_count <= mismatches;
        pending    <= callbacks_due.size();
    end

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ucts_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned MAX_GAP     = 100;
    localparam int unsigned PHASE_BEATS = 320;
    localparam int unsigned LONG_PKTS   = 517;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam logic [2:0]  FN_UNUSED   = 3'd7;
    localparam logic [2:0]  PT_BAD      = 3'd7;

    logic        clk;
    logic        rst_n;
    int unsigned send_idle   = 0;
    int unsigned recv_stall  = 0;
    int unsigned beats_sent  = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count;
    int unsigned pending;

    ucts_cmd_if cmd_bus ();
    ucts_rsp_if rsp_bus ();

    usb_control_transfer_stage_fsm i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    usb_ctrl_stage_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_bus),
        .rsp        (rsp_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at the current phase rate
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // End the run if neither channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("usb_control_transfer_stage_fsm regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic item_t rand_fields();
        logic [63:0] bits;
        item_t       it;
        bits = {$urandom, $urandom};
        it   = bits[$bits(item_t)-1:0];
        return it;
    endfunction

    function automatic logic signed [7:0] rand_err();
        int v;
        if ($urandom_range(3) != 0)
            return 8'sd0;
        v = $urandom_range(128, 1);
        return 8'(-v);
    endfunction

    function automatic item_t mk_item(
        input logic [2:0]        func,
        input logic [2:0]        pt,
        input logic [6:0]        size,
        input logic signed [7:0] err,
        input logic [7:0]        rtype,
        input logic [15:0]       wlen,
        input logic [4:0]        ep
    );
        item_t it;
        it.func         = func;
        it.pkt_type     = pt;
        it.pkt_size     = size;
        it.error_in     = err;
        it.request_type = rtype;
        it.setup_length = wlen;
        it.endpoint     = ep;
        return it;
    endfunction

    function automatic item_t packet_item(input logic [2:0] pt);
        item_t it;
        it          = rand_fields();
        it.func     = FN_PKT;
        it.pkt_type = pt;
        it.pkt_size = 7'($urandom_range(64));
        it.error_in = rand_err();
        return it;
    endfunction

    task automatic present(input item_t it);
        cmd_bus.func         <= it.func;
        cmd_bus.pkt_type     <= it.pkt_type;
        cmd_bus.pkt_size     <= it.pkt_size;
        cmd_bus.error_in     <= it.error_in;
        cmd_bus.request_type <= it.request_type;
        cmd_bus.setup_length <= it.setup_length;
        cmd_bus.endpoint     <= it.endpoint;
    endtask

    // Idle for a random gap, then hold the beat until it is taken
    task automatic push_beat(input item_t it);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        present(it);
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        if (it.func <= FN_STALL)
            beats_sent++;
    endtask

    // Hold off the sender until every queued callback has come back
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Scatter client read, write and send-status requests
    task automatic maybe_requests();
        item_t it;
        while ($urandom_range(9) < 3)
        begin
            it      = rand_fields();
            it.func = 3'($urandom_range(3, 1));
            push_beat(it);
        end
    endtask

    // Now and then break the transfer: stall, stray packet or a fresh setup, or send an ignored function code
    task automatic maybe_disrupt(output bit cut);
        item_t it;
        cut = ($urandom_range(99) < 8);
        if (cut)
        begin
            it = rand_fields();
            case ($urandom_range(3))
                0:
                begin
                    it.func = FN_STALL;
                    push_beat(it);
                end
                1:
                begin
                    it.func     = FN_PKT;
                    it.error_in = rand_err();
                    push_beat(it);
                end
                2:
                begin
                    // ignored code, transfer carries on
                    it.func = 3'($urandom_range(7, 5));
                    push_beat(it);
                    cut = 1'b0;
                end
                default:
                begin
                    // next setup lands mid-transfer
                end
            endcase
        end
    endtask

    // One control transfer with random content
    task automatic run_transfer();
        item_t       it;
        logic [15:0] wlen;
        logic        to_host;
        int unsigned sofar;
        int unsigned npkt;
        bit          cut;
        if ($urandom_range(9) == 0)
            push_beat(rand_fields());
        case ($urandom_range(7))
            0, 1:    wlen = 16'd0;
            2, 3, 4: wlen = 16'($urandom_range(64, 1));
            5, 6:    wlen = 16'($urandom_range(400, 65));
            default: wlen = 16'($urandom);
        endcase
        to_host = 1'($urandom_range(1));
        it                 = packet_item(PT_SETUP);
        it.pkt_size        = ($urandom_range(3) == 0) ? 7'($urandom_range(64)) : 7'd8;
        it.request_type[7] = to_host;
        it.setup_length    = wlen;
        push_beat(it);
        maybe_requests();
        maybe_disrupt(cut);
        if (cut)
            return;
        if (wlen != 16'd0 && to_host)
        begin
            push_beat(packet_item(PT_DIN));
            maybe_requests();
            maybe_disrupt(cut);
            if (cut)
                return;
            push_beat(packet_item(PT_SOUT));
        end
        else
        begin
            sofar = 0;
            npkt  = 0;
            while (sofar < wlen && npkt < 12)
            begin
                it = packet_item(PT_DOUT);
                sofar += it.pkt_size;
                npkt++;
                push_beat(it);
                maybe_requests();
                maybe_disrupt(cut);
                if (cut)
                    return;
            end
            if ($urandom_range(1) == 0)
            begin
                it      = rand_fields();
                it.func = FN_STATUS;
                push_beat(it);
            end
            else
                push_beat(packet_item(PT_SIN));
        end
        maybe_requests();
    endtask

    task automatic run_phase(
        input int unsigned idle_pct,
        input int unsigned stall_pct,
        input int unsigned quota
    );
        int unsigned stop_at;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        stop_at    = beats_sent + quota;
        while (beats_sent < stop_at)
            run_transfer();
        drain();
    endtask

    initial
    begin
        item_t it;
        rst_n         <= 1'b0;
        cmd_bus.valid <= 1'b0;
        present('0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every function, abandoned stages, wrong packet types
        push_beat(mk_item(FN_STALL, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'h0000, 5'd31));
        push_beat(mk_item(FN_PKT, PT_DOUT, 7'd64, 8'sd0, 8'h00, 16'h0000, 5'd0));
        push_beat(mk_item(FN_UNUSED, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'h0000, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_STATUS, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_STATUS, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd64, 8'sh80, 8'h80, 16'd8, 5'd0));
        push_beat(mk_item(FN_READ, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_WRITE, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_DIN, 7'd64, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'shFF, 8'h00, 16'd3, 5'd0));
        push_beat(mk_item(FN_READ, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_READ, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_DOUT, 7'd2, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd0, 8'sd0, 8'hFF, 16'hFFFF, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sh81, 8'h7F, 16'd1, 5'd0));
        push_beat(mk_item(FN_PKT, PT_DOUT, 7'd1, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SIN, 7'd0, 8'shC0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h00, 16'd5, 5'd0));
        push_beat(mk_item(FN_PKT, PT_BAD, 7'd4, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h80, 16'd2, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SOUT, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_DIN, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h00, 16'd64, 5'd0));
        push_beat(mk_item(FN_PKT, PT_SIN, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd0));
        push_beat(mk_item(FN_STALL, PT_SETUP, 7'd0, 8'sd0, 8'h00, 16'd0, 5'd21));
        drain();

        // Long data out stage that drives the byte count into saturation
        push_beat(mk_item(FN_PKT, PT_SETUP, 7'd8, 8'sd0, 8'h00, 16'hFFFF, 5'd0));
        repeat (LONG_PKTS)
        begin
            it          = packet_item(PT_DOUT);
            it.pkt_size = 7'd127;
            it.error_in = 8'sd0;
            push_beat(it);
        end
        push_beat(packet_item(PT_SIN));
        drain();

        // Random transfers under each idle and stall mix
        run_phase(0, 0, PHASE_BEATS);
        run_phase(80, 0, PHASE_BEATS);
        run_phase(0, 80, PHASE_BEATS);
        run_phase(36, 36, PHASE_BEATS);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("usb_control_transfer_stage_fsm regression: pass");
        else
            $display("usb_control_transfer_stage_fsm regression: fail");
        $finish;
    end

endmodule
